/* design/accel_tilt_roll_pitch_unit_defines.svh */
// ---------------------------------------------------------------------------
// accel tilt roll pitch unit: shared assertion macros
// Immediate-consequence and next-cycle property wrappers on clk_i / rst_ni.
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_ROLL_PITCH_UNIT_DEFINES_SVH
`define ACCEL_TILT_ROLL_PITCH_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define ATRP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ATRP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/atrp_pkg.sv */
// ---------------------------------------------------------------------------
// atrp_pkg
// Widths, arctangent table and inter-module structs of the tilt unit.
// ---------------------------------------------------------------------------
package atrp_pkg;

  // sample and result widths
  localparam int IN_W    = 16;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;

  // integer square root of (y*y + z*z) * 2^30
  localparam int SQ_W     = 2 * IN_W - 1;
  localparam int SUM_W    = SQ_W + 1;
  localparam int FRAC_SH  = 30;
  localparam int REM_W    = SUM_W + FRAC_SH;
  localparam int TRIAL_W  = REM_W + 1;
  localparam int ROOT_W   = REM_W / 2;
  localparam int SQ_STEPS = ROOT_W;

  // cordic datapath
  localparam int OPD_SH        = 15;
  localparam int CW            = 34;
  localparam int ANG_W         = 24;
  localparam int ATAN_W        = 20;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_ITER      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  localparam logic signed [ANG_W-1:0] PI_Q20 = ANG_W'(3294199);

  // atan(2^-i) in Q20, rounded to nearest
  localparam logic [ATAN_W-1:0] ATAN_Q20 [TABLE_LEN] = '{
    ATAN_W'(823550), ATAN_W'(486170), ATAN_W'(256879), ATAN_W'(130396),
    ATAN_W'(65451),  ATAN_W'(32757),  ATAN_W'(16383),  ATAN_W'(8192),
    ATAN_W'(4096),   ATAN_W'(2048),   ATAN_W'(1024),   ATAN_W'(512),
    ATAN_W'(256),    ATAN_W'(128),    ATAN_W'(64),     ATAN_W'(32),
    ATAN_W'(16),     ATAN_W'(8),      ATAN_W'(4),      ATAN_W'(2),
    ATAN_W'(1),      ATAN_W'(0),      ATAN_W'(0),      ATAN_W'(0)
  };

  // Q20 to Q13 rounding and output clamps
  localparam int RND_SHIFT = 7;
  localparam int RQ_W      = ANG_W - RND_SHIFT;
  localparam logic signed [ANG_W-1:0] RND_HALF  = ANG_W'(64);
  localparam logic signed [RQ_W-1:0]  ROLL_MAX  = RQ_W'(25736);
  localparam logic signed [RQ_W-1:0]  PITCH_MAX = RQ_W'(12868);

  // square root pipeline output with the sample carried alongside
  typedef struct packed {
    logic                    valid;
    logic signed [IN_W-1:0]  ax;
    logic signed [IN_W-1:0]  ay;
    logic signed [IN_W-1:0]  az;
    logic [ROOT_W-1:0]       root;
  } atrp_root_t;

  // cordic lane output
  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic signed [ANG_W-1:0] ang;
  } atrp_angle_t;

endpackage

/* design/atrp_isqrt.sv */
// ---------------------------------------------------------------------------
// atrp_isqrt
// Squares, sum and a restoring square root, one root bit per stage.
// ---------------------------------------------------------------------------
`include "accel_tilt_roll_pitch_unit_defines.svh"

module atrp_isqrt
  import atrp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [IN_W-1:0] ax_i,
  input  logic signed [IN_W-1:0] ay_i,
  input  logic signed [IN_W-1:0] az_i,
  output atrp_root_t             root_o
);

  // sample side data, index 0 is the square stage
  logic                   vld_q [SQ_STEPS+2];
  logic signed [IN_W-1:0] ax_q  [SQ_STEPS+2];
  logic signed [IN_W-1:0] ay_q  [SQ_STEPS+2];
  logic signed [IN_W-1:0] az_q  [SQ_STEPS+2];

  // remainder and partial root, index 0 is the sum stage
  logic [REM_W-1:0]  rem_q [SQ_STEPS+1];
  logic [ROOT_W-1:0] q_q   [SQ_STEPS+1];

  logic [SQ_W-1:0]  sq_y_q, sq_z_q;
  logic signed [2*IN_W-1:0] prod_y, prod_z;
  logic [SUM_W-1:0] sum_d;

  // squares
  assign prod_y = ay_i * ay_i;
  assign prod_z = az_i * az_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_y_q   <= prod_y[SQ_W-1:0];
      sq_z_q   <= prod_z[SQ_W-1:0];
      ax_q[0]  <= ax_i;
      ay_q[0]  <= ay_i;
      az_q[0]  <= az_i;
    end
  end

  // sum of squares, scaled to a Q30 radicand
  assign sum_d = SUM_W'(sq_y_q) + SUM_W'(sq_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[1] <= 1'b0;
    end else if (en_i) begin
      vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {sum_d, {FRAC_SH{1'b0}}};
      q_q[0]   <= '0;
      ax_q[1]  <= ax_q[0];
      ay_q[1]  <= ay_q[0];
      az_q[1]  <= az_q[0];
    end
  end

  // root bits, most significant first
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam int K = SQ_STEPS - 1 - j;

    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] diff;
    logic               take;
    logic [REM_W-1:0]   rem_d;
    logic [ROOT_W-1:0]  q_d;

    always_comb begin
      trial = (TRIAL_W'(q_q[j]) << (K + 1)) + (TRIAL_W'(1) << (2 * K));
      diff  = TRIAL_W'(rem_q[j]) - trial;
      take  = TRIAL_W'(rem_q[j]) >= trial;
      rem_d = take ? diff[REM_W-1:0] : rem_q[j];
      q_d   = take ? (q_q[j] | (ROOT_W'(1) << K)) : q_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+2] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+2] <= vld_q[j+1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= rem_d;
        q_q[j+1]    <= q_d;
        ax_q[j+2]   <= ax_q[j+1];
        ay_q[j+2]   <= ay_q[j+1];
        az_q[j+2]   <= az_q[j+1];
      end
    end
  end

  assign root_o.valid = vld_q[SQ_STEPS+1];
  assign root_o.ax    = ax_q[SQ_STEPS+1];
  assign root_o.ay    = ay_q[SQ_STEPS+1];
  assign root_o.az    = az_q[SQ_STEPS+1];
  assign root_o.root  = q_q[SQ_STEPS];

  // floor root: what is left of the radicand never reaches 2*root + 1
  `ATRP_ASSERT_NOW(a_root_is_floor, vld_q[SQ_STEPS+1],
                   rem_q[SQ_STEPS] <= (REM_W'(q_q[SQ_STEPS]) << 1),
                   "square root remainder exceeds twice the root")

endmodule

/* design/atrp_cordic.sv */
// ---------------------------------------------------------------------------
// atrp_cordic
// Vectoring cordic for atan2(a, b): half-turn pre-rotation, then one
// micro-rotation per register stage, angle kept in Q20.
// ---------------------------------------------------------------------------
module atrp_cordic
  import atrp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] a_i,
  input  logic signed [CW-1:0] b_i,
  output atrp_angle_t          ang_o
);

  logic                    vld_q  [NUM_ITER+1];
  logic                    zero_q [NUM_ITER+1];
  logic signed [CW-1:0]    x_q    [NUM_ITER+1];
  logic signed [CW-1:0]    y_q    [NUM_ITER+1];
  logic signed [ANG_W-1:0] ang_q  [NUM_ITER+1];

  logic                    zero_d;
  logic signed [CW-1:0]    x_d, y_d;
  logic signed [ANG_W-1:0] ang_d;

  // pre-rotation into the right half plane
  always_comb begin
    zero_d = (a_i == '0) && (b_i == '0);
    if (b_i < 0) begin
      x_d   = -b_i;
      y_d   = -a_i;
      ang_d = (a_i >= 0) ? PI_Q20 : -PI_Q20;
    end else begin
      x_d   = b_i;
      y_d   = a_i;
      ang_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= zero_d;
      x_q[0]    <= x_d;
      y_q[0]    <= y_d;
      ang_q[0]  <= ang_d;
    end
  end

  // micro-rotations, driving y towards zero
  for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
    logic signed [CW-1:0]    dx, dy, xn, yn;
    logic signed [ANG_W-1:0] step, an;

    always_comb begin
      dx   = y_q[i] >>> i;
      dy   = x_q[i] >>> i;
      step = signed'(ANG_W'(ATAN_Q20[i]));
      if (y_q[i] >= 0) begin
        xn = x_q[i] + dx;
        yn = y_q[i] - dy;
        an = ang_q[i] + step;
      end else begin
        xn = x_q[i] - dx;
        yn = y_q[i] + dy;
        an = ang_q[i] - step;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        x_q[i+1]    <= xn;
        y_q[i+1]    <= yn;
        ang_q[i+1]  <= an;
      end
    end
  end

  assign ang_o.valid = vld_q[NUM_ITER];
  assign ang_o.zero  = zero_q[NUM_ITER];
  assign ang_o.ang   = ang_q[NUM_ITER];

endmodule

/* design/accel_tilt_roll_pitch_unit.sv */
// ---------------------------------------------------------------------------
// accel_tilt_roll_pitch_unit
// Roll = atan2(y, z) in Q3.13 and pitch = atan2(-x, sqrt(y^2 + z^2)) in
// Q2.13, radians, from one signed three-axis accelerometer sample.
// ---------------------------------------------------------------------------
//  channel  handshake                  payload
//  -------  -------------------------  ----------------------------------
//  input    in_valid_i / in_ready_o    accel_x_i, accel_y_i, accel_z_i
//  output   out_valid_o / out_ready_i  roll_angle_o, pitch_angle_o
//
//  one item per cycle while the output is not stalled; pipeline stages:
//  2 square/sum stages, 31 root stages, cordic pre-rotation plus one stage
//  per iteration, and the output register.
//  the 31-step root pipeline sets the depth; roll and pitch cordics run
//  side by side after it.
//  reset clears every valid bit; payload registers are not reset.
//  a stall on the output freezes the whole pipeline in place.
// ---------------------------------------------------------------------------
`include "accel_tilt_roll_pitch_unit_defines.svh"

module accel_tilt_roll_pitch_unit
  import atrp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [IN_W-1:0]    accel_x_i,
  input  logic signed [IN_W-1:0]    accel_y_i,
  input  logic signed [IN_W-1:0]    accel_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ROLL_W-1:0]  roll_angle_o,
  output logic signed [PITCH_W-1:0] pitch_angle_o
);

  logic        en;
  atrp_root_t  root_res;
  atrp_angle_t roll_res, pitch_res;

  logic signed [CW-1:0]     roll_a, roll_b, pitch_a, pitch_b;
  logic signed [IN_W:0]     neg_x;
  logic signed [ANG_W-1:0]  roll_sum, pitch_sum;
  logic signed [RQ_W-1:0]   roll_rq, pitch_rq, roll_c, pitch_c;

  logic                      out_valid_q;
  logic signed [ROLL_W-1:0]  roll_q, roll_d;
  logic signed [PITCH_W-1:0] pitch_q, pitch_d;

  // whole pipeline moves unless a finished item is held at the output
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  atrp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .ax_i    (accel_x_i),
    .ay_i    (accel_y_i),
    .az_i    (accel_z_i),
    .root_o  (root_res)
  );

  // cordic operands in Q15
  always_comb begin
    neg_x   = -(IN_W+1)'(root_res.ax);
    roll_a  = signed'(CW'(root_res.ay)) <<< OPD_SH;
    roll_b  = signed'(CW'(root_res.az)) <<< OPD_SH;
    pitch_a = signed'(CW'(neg_x)) <<< OPD_SH;
    pitch_b = signed'(CW'(root_res.root));
  end

  atrp_cordic u_cordic_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (root_res.valid),
    .a_i     (roll_a),
    .b_i     (roll_b),
    .ang_o   (roll_res)
  );

  atrp_cordic u_cordic_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (root_res.valid),
    .a_i     (pitch_a),
    .b_i     (pitch_b),
    .ang_o   (pitch_res)
  );

  // Q20 to Q13 with halves rounded up, clamp, zero vector gives zero
  always_comb begin
    roll_sum  = roll_res.ang + RND_HALF;
    pitch_sum = pitch_res.ang + RND_HALF;
    roll_rq   = $signed(roll_sum[ANG_W-1:RND_SHIFT]);
    pitch_rq  = $signed(pitch_sum[ANG_W-1:RND_SHIFT]);

    if (roll_res.zero) begin
      roll_c = '0;
    end else if (roll_rq > ROLL_MAX) begin
      roll_c = ROLL_MAX;
    end else if (roll_rq < -ROLL_MAX) begin
      roll_c = -ROLL_MAX;
    end else begin
      roll_c = roll_rq;
    end

    if (pitch_res.zero) begin
      pitch_c = '0;
    end else if (pitch_rq > PITCH_MAX) begin
      pitch_c = PITCH_MAX;
    end else if (pitch_rq < -PITCH_MAX) begin
      pitch_c = -PITCH_MAX;
    end else begin
      pitch_c = pitch_rq;
    end

    roll_d  = roll_c[ROLL_W-1:0];
    pitch_d = pitch_c[PITCH_W-1:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= roll_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;

  // both cordic lanes carry the same item at all times
  `ATRP_ASSERT_NOW(a_lanes_aligned, 1'b1, roll_res.valid == pitch_res.valid,
                   "roll and pitch lanes out of step")

  // results stay inside their angle ranges
  `ATRP_ASSERT_NOW(a_roll_range, out_valid_q,
                   (RQ_W'(roll_q) <= ROLL_MAX) && (RQ_W'(roll_q) >= -ROLL_MAX),
                   "roll angle outside range")

  `ATRP_ASSERT_NOW(a_pitch_range, out_valid_q,
                   (RQ_W'(pitch_q) <= PITCH_MAX) && (RQ_W'(pitch_q) >= -PITCH_MAX),
                   "pitch angle outside range")

  // input held off only while a finished item is waiting, which then stays
  `ATRP_ASSERT_NEXT(a_stall_keeps_item, !in_ready_o, out_valid_q,
                    "held output item lost during stall")

endmodule

/* bench/tilt_angle_checker.sv */
// ---------------------------------------------------------------------------
// tilt_angle_checker
// Watches both channels of the tilt unit, predicts roll and pitch for every
// accepted sample with a bit-exact vectoring cordic of its own, and compares
// each accepted result in order against the oldest prediction.
// ---------------------------------------------------------------------------
module tilt_angle_checker
  import atrp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [IN_W-1:0]    accel_x_i,
  input  logic signed [IN_W-1:0]    accel_y_i,
  input  logic signed [IN_W-1:0]    accel_z_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [ROLL_W-1:0]  roll_angle_i,
  input  logic signed [PITCH_W-1:0] pitch_angle_i,
  output int                        mismatch_count_o,
  output int                        pending_o
);

  // arctangent steps atan(2^-i) in q20, only 24 of them exist
  localparam int ARCTAN_LEN = 24;
  localparam longint ARCTAN_Q20 [ARCTAN_LEN] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0, 0, 0
  };
  localparam int     ROTATIONS   = (CORDIC_STAGES < ARCTAN_LEN) ? CORDIC_STAGES : ARCTAN_LEN;
  localparam longint HALF_TURN   = 3294199;
  localparam longint ROLL_LIMIT  = 25736;
  localparam longint PITCH_LIMIT = 12868;

  typedef struct {
    logic signed [IN_W-1:0]    x;
    logic signed [IN_W-1:0]    y;
    logic signed [IN_W-1:0]    z;
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
  } tilt_angles_t;

  tilt_angles_t pending_angles[$];
  int           n_bad;

  initial begin
    n_bad            = 0;
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  // exact integer square root, digit by digit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = 64'h1 << 62;
    while (probe > v)
      probe >>= 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v   -= res + probe;
        res  = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // atan2(a, b) in q13 by vectoring cordic, clamped to [-lim, lim]
  function automatic longint atan2_q13(longint a, longint b, longint lim);
    longint xr;
    longint yr;
    longint acc;
    longint dx;
    longint dy;
    longint q;
    if (a == 0 && b == 0)
      return 0;
    xr  = b;
    yr  = a;
    acc = 0;
    // left half plane: turn by half a circle first
    if (b < 0) begin
      acc = (a >= 0) ? HALF_TURN : -HALF_TURN;
      xr  = -b;
      yr  = -a;
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr >= 0) begin
        xr  += dx;
        yr  -= dy;
        acc += ARCTAN_Q20[i];
      end else begin
        xr  -= dx;
        yr  += dy;
        acc -= ARCTAN_Q20[i];
      end
    end
    // q20 to q13, halves round up
    q = (acc + 64) >>> 7;
    if (q > lim)
      q = lim;
    if (q < -lim)
      q = -lim;
    return q;
  endfunction

  function automatic tilt_angles_t predict_tilt(logic signed [IN_W-1:0] x,
                                                logic signed [IN_W-1:0] y,
                                                logic signed [IN_W-1:0] z);
    tilt_angles_t    t;
    longint          ax;
    longint          ay;
    longint          az;
    longint unsigned sumsq;
    longint          radius;
    ax       = longint'(x);
    ay       = longint'(y);
    az       = longint'(z);
    sumsq    = longint'(ay * ay + az * az);
    radius   = longint'(int_sqrt(sumsq << 30));
    t.x      = x;
    t.y      = y;
    t.z      = z;
    t.roll   = ROLL_W'(atan2_q13(ay * 32768, az * 32768, ROLL_LIMIT));
    t.pitch  = PITCH_W'(atan2_q13(-ax * 32768, radius, PITCH_LIMIT));
    return t;
  endfunction

  // compare results in order, then queue the prediction for a new sample
  always @(posedge clk_i) begin : watch
    tilt_angles_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending_angles.size() == 0) begin
          $display("%0t: unexpected result, expected none, got roll %0d pitch %0d",
                   $time, roll_angle_i, pitch_angle_i);
          n_bad++;
        end else begin
          want = pending_angles.pop_front();
          if (roll_angle_i !== want.roll) begin
            $display("%0t: roll mismatch for (%0d,%0d,%0d), expected %0d, got %0d",
                     $time, want.x, want.y, want.z, want.roll, roll_angle_i);
            n_bad++;
          end
          if (pitch_angle_i !== want.pitch) begin
            $display("%0t: pitch mismatch for (%0d,%0d,%0d), expected %0d, got %0d",
                     $time, want.x, want.y, want.z, want.pitch, pitch_angle_i);
            n_bad++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        pending_angles.push_back(predict_tilt(accel_x_i, accel_y_i, accel_z_i));
    end
    mismatch_count_o <= n_bad;
    pending_o        <= pending_angles.size();
  end

endmodule

/* bench/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Drives accelerometer samples into the tilt unit in random bursts while the
// result side stalls on its own pattern: a directed set of axis extremes and
// zero vectors first, then random samples of several flavours. Checking is
// done by tilt_angle_checker; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
  import atrp_pkg::*;

  localparam int N_RANDOM   = 1600;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 120;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [IN_W-1:0]    accel_x_i;
  logic signed [IN_W-1:0]    accel_y_i;
  logic signed [IN_W-1:0]    accel_z_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [ROLL_W-1:0]  roll_angle_o;
  logic signed [PITCH_W-1:0] pitch_angle_o;

  int mismatch_count;
  int pending;
  int burst_left;
  int gap;
  int idle_cycles;
  int ready_mode;
  int ready_left;
  int stall_phase;

  accel_tilt_roll_pitch_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .roll_angle_o (roll_angle_o),
    .pitch_angle_o(pitch_angle_o)
  );

  tilt_angle_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .roll_angle_i    (roll_angle_o),
    .pitch_angle_i   (pitch_angle_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: stall pattern switches between free run, light, cyclic and heavy
  initial begin
    out_ready_i <= 1'b0;
    ready_mode   = 0;
    ready_left   = 0;
    stall_phase  = 0;
  end

  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(40, 300);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= ($urandom_range(0, 4) != 0);
      end
      2: begin
        out_ready_i <= ((stall_phase % 7) < 4);
      end
      default: begin
        out_ready_i <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // watchdog on cycles with no item moving on either channel
  initial idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one sample, preceded by a random gap, possibly none, when a burst has run out
  task automatic send_sample(input logic signed [IN_W-1:0] x,
                             input logic signed [IN_W-1:0] y,
                             input logic signed [IN_W-1:0] z);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    accel_x_i  <= x;
    accel_y_i  <= y;
    accel_z_i  <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // axis extremes and values around them
  function automatic logic signed [IN_W-1:0] corner_value();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return 16'sd32767;
      3:       return -16'sd1;
      4:       return 16'sd0;
      5:       return 16'sd1;
      6:       return IN_W'($urandom_range(0, 8)) - 16'sd4;
      default: return IN_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [IN_W-1:0] gravity_value();
    return IN_W'($urandom_range(0, 36000)) - 16'sd18000;
  endfunction

  function automatic logic signed [IN_W-1:0] tiny_value();
    return IN_W'($urandom_range(0, 32)) - 16'sd16;
  endfunction

  initial begin
    int pick;
    logic signed [IN_W-1:0] rx;
    logic signed [IN_W-1:0] ry;
    logic signed [IN_W-1:0] rz;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    accel_x_i  <= '0;
    accel_y_i  <= '0;
    accel_z_i  <= '0;
    burst_left  = 0;
    gap         = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both atan2 arguments zero, for roll and for pitch
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd123, 16'sd0, 16'sd0);
    send_sample(-16'sd32768, 16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd0, 16'sd0);
    // level and upside down, half turn on either side
    send_sample(16'sd0, 16'sd0, 16'sd16384);
    send_sample(16'sd0, 16'sd0, -16'sd16384);
    send_sample(16'sd0, -16'sd1, -16'sd32768);
    send_sample(16'sd0, 16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sd0, 16'sd1);
    // quadrant corners at full scale
    send_sample(16'sd0, -16'sd32768, -16'sd32768);
    send_sample(16'sd0, 16'sd32767, -16'sd32768);
    send_sample(16'sd0, 16'sd32767, 16'sd32767);
    send_sample(16'sd0, -16'sd32768, 16'sd32767);
    send_sample(16'sd0, 16'sd32767, 16'sd0);
    send_sample(16'sd0, -16'sd32768, 16'sd0);
    // most negative sample on every axis and mixed extremes
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
    // pitch close to its bound
    send_sample(-16'sd32768, 16'sd1, 16'sd0);
    send_sample(16'sd16384, 16'sd0, 16'sd1);
    send_sample(-16'sd1, 16'sd0, -16'sd1);
    send_sample(16'sd1, 16'sd1, -16'sd1);
    send_sample(16'sd0, 16'sd1, 16'sd0);

    // random samples of mixed flavours
    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        rx = IN_W'($urandom);
        ry = IN_W'($urandom);
        rz = IN_W'($urandom);
      end else if (pick < 60) begin
        rx = gravity_value();
        ry = gravity_value();
        rz = gravity_value();
      end else if (pick < 75) begin
        rx = tiny_value();
        ry = tiny_value();
        rz = tiny_value();
      end else if (pick < 90) begin
        rx = corner_value();
        ry = corner_value();
        rz = corner_value();
      end else begin
        // each axis zero at random
        rx = ($urandom_range(0, 2) == 0) ? 16'sd0 : IN_W'($urandom);
        ry = ($urandom_range(0, 1) == 0) ? 16'sd0 : corner_value();
        rz = ($urandom_range(0, 1) == 0) ? 16'sd0 : corner_value();
      end
      send_sample(rx, ry, rz);
    end
    in_valid_i <= 1'b0;

    // drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (mismatch_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
